FILE: rtl/bmpm_pkg.sv
// Shared definitions for the blend mode pixel mixer.
// Holds the blend mode codes, the pipeline enable struct and the exact divide-by-255 helper.
// No dependencies; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package bmpm_pkg;

    // Blend mode register codes. Codes 9 to 15 pass the source color through.
    localparam logic [3:0] MODE_NORMAL   = 4'd0;
    localparam logic [3:0] MODE_OVERLAY  = 4'd1;
    localparam logic [3:0] MODE_ADD      = 4'd2;
    localparam logic [3:0] MODE_SUBTRACT = 4'd3;
    localparam logic [3:0] MODE_MULTIPLY = 4'd4;
    localparam logic [3:0] MODE_SCREEN   = 4'd5;
    localparam logic [3:0] MODE_DIFF     = 4'd6;
    localparam logic [3:0] MODE_REV_SUB  = 4'd7;
    localparam logic [3:0] MODE_INV_SUB  = 4'd8;

    localparam logic [7:0] CHAN_MAX   = 8'hff;
    localparam logic [8:0] ALPHA_ONE  = 9'h100;

    // Register index of the only configuration register.
    localparam logic REG_BLEND_MODE = 1'b0;

    // Load enables of the first two pipeline stages.
    typedef struct packed {
        logic en1;
        logic en2;
    } t_pipe_ctl;

    // Exact floor(x / 255) for x in 0..65025.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] x1;
        logic [16:0] sum;
        x1  = {1'b0, x} + 17'd1;
        sum = x1 + {8'd0, x1[16:8]};
        return sum[15:8];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/blend_mode_pixel_mixer.sv
// Top level of the blend mode pixel mixer: APB register, pipeline control and datapath.
// Depends on bmpm_pkg, bmpm_blend_chan and bmpm_mix_chan.
//
// Usage: each input beat carries a destination pixel (ARGB bytes), a source color
// whose top byte is the source alpha, and a coverage byte where 64 means full.
// Each output beat carries the mixed destination pixel in the same byte layout.
// Both channels use valid/ready; one output beat is produced for every input beat,
// in order.
//
// A beat accepted into stage 1 moves on to stages 2 and 3, and the stage 3 valid flag
// drives o_out_valid; the beat leaves when the output side is not stalling. The
// pipeline takes one beat per clock while the output side is not stalling; the three
// stages are the operand multiply, the exact divide by 255 with mode selection, and the
// final alpha mix. The last stage register is the output register.
//
// When the receiver stalls, each stage holds its beat while the stage after it is
// full, and o_in_ready drops only when all three stages are occupied. Empty stages
// keep filling, so no beat is lost or repeated.
//
// Reset (i_rst_n low, synchronous) empties the pipeline and sets blend_mode to
// normal. The blend_mode register sits at APB address 0 and must only be written
// while the pipeline is empty.
`default_nettype none

module blend_mode_pixel_mixer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input beat channel.
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_dst_pixel,
    input  wire logic [31:0] i_src_color,
    input  wire logic [7:0]  i_coverage,
    // Output beat channel.
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [31:0] o_mixed_pixel,
    // APB configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    bmpm_pkg::t_pipe_ctl w_ctl;
    logic                w_en3;
    logic                w_accept;
    logic [15:0]         w_alpha_prod;
    logic [23:0]         w_b;
    logic [23:0]         w_d;

    logic [3:0]          r_mode;
    logic                r_v1;
    logic                r_v2;
    logic                r_v3;
    logic [7:0]          r_a1;
    logic [7:0]          r_a2;
    logic [7:0]          r_da1;
    logic [7:0]          r_da2;

    // ------------------------------------------------------------------
    // Configuration register. Only the low four bits of the data are kept.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == bmpm_pkg::REG_BLEND_MODE) ? {28'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= bmpm_pkg::MODE_NORMAL;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == bmpm_pkg::REG_BLEND_MODE)) begin
            r_mode <= pwdata[3:0];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. A stage loads when it is empty or its beat moves on.
    // ------------------------------------------------------------------
    assign w_en3      = !r_v3 || i_out_ready;
    assign w_ctl.en2  = !r_v2 || w_en3;
    assign w_ctl.en1  = !r_v1 || w_ctl.en2;
    assign o_in_ready = w_ctl.en1;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_ctl.en1) begin
                r_v1 <= w_accept;
            end
            if (w_ctl.en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    assign o_out_valid = r_v3;

    // ------------------------------------------------------------------
    // Effective alpha. Coverage above full wraps through the byte mask.
    // ------------------------------------------------------------------
    assign w_alpha_prod = i_coverage * i_src_color[31:24];

    always_ff @(posedge i_clk) begin
        if (w_ctl.en1) begin
            r_a1  <= w_alpha_prod[13:6];
            r_da1 <= i_dst_pixel[31:24];
        end
        if (w_ctl.en2) begin
            r_a2  <= r_a1;
            r_da2 <= r_da1;
        end
    end

    // ------------------------------------------------------------------
    // Color channels: blend in stages 1 and 2, mix in stage 3.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < 3; g++) begin : g_chan
        bmpm_blend_chan u_blend (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_mode (r_mode),
            .i_c    (i_src_color[8*g +: 8]),
            .i_d    (i_dst_pixel[8*g +: 8]),
            .o_b    (w_b[8*g +: 8]),
            .o_d    (w_d[8*g +: 8])
        );

        bmpm_mix_chan u_mix (
            .i_clk (i_clk),
            .i_en  (w_en3),
            .i_d   (w_d[8*g +: 8]),
            .i_b   (w_b[8*g +: 8]),
            .i_a   (r_a2),
            .o_m   (o_mixed_pixel[8*g +: 8])
        );
    end

    // The alpha byte mixes against a blended value of zero.
    bmpm_mix_chan u_mix_alpha (
        .i_clk (i_clk),
        .i_en  (w_en3),
        .i_d   (r_da2),
        .i_b   (8'd0),
        .i_a   (r_a2),
        .o_m   (o_mixed_pixel[31:24])
    );

`ifndef ASSERT_OFF
    // An accepted beat always occupies the first stage afterwards.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_v1)
        else $error("accepted beat did not enter stage 1");

    // Input is refused only when every stage is full and the output stalls.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_v1 && r_v2 && r_v3 && !i_out_ready))
        else $error("input refused with room in the pipeline");

    // A stalled output beat keeps its stage valid and its payload.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !i_out_ready) |=> (r_v3 && $stable(o_mixed_pixel)))
        else $error("stalled output beat was lost or changed");
`endif

endmodule

`default_nettype wire

FILE: rtl/bmpm_blend_chan.sv
// One color channel of the blend stage: operand product in stage 1, blend result in stage 2.
// Depends on bmpm_pkg for the mode codes, the enable struct and div255.
`default_nettype none

module bmpm_blend_chan (
    input  wire logic                 i_clk,
    input  wire bmpm_pkg::t_pipe_ctl  i_ctl,
    input  wire logic [3:0]           i_mode,
    input  wire logic [7:0]           i_c,
    input  wire logic [7:0]           i_d,
    output logic      [7:0]           o_b,
    output logic      [7:0]           o_d
);

    logic        w_inv;
    logic [7:0]  w_opc;
    logic [7:0]  w_opd;
    logic [8:0]  w_sum;
    logic [7:0]  w_inv_d;
    logic [7:0]  n_simple;
    logic [7:0]  w_q;
    logic [7:0]  w_q2;
    logic [7:0]  n_b;

    logic [15:0] r_prod;
    logic [7:0]  r_simple;
    logic [3:0]  r_mode;
    logic        r_inv;
    logic [7:0]  r_d1;
    logic [7:0]  r_b2;
    logic [7:0]  r_d2;

    // Screen and the upper half of overlay work on inverted operands.
    assign w_inv = (i_mode == bmpm_pkg::MODE_SCREEN) ||
                   ((i_mode == bmpm_pkg::MODE_OVERLAY) && i_d[7]);
    assign w_opc = w_inv ? ~i_c : i_c;
    assign w_opd = w_inv ? ~i_d : i_d;
    assign w_sum = {1'b0, i_c} + {1'b0, i_d};
    assign w_inv_d = ~i_d;

    always_comb begin
        case (i_mode)
            bmpm_pkg::MODE_ADD: begin
                n_simple = w_sum[8] ? bmpm_pkg::CHAN_MAX : w_sum[7:0];
            end
            bmpm_pkg::MODE_SUBTRACT: begin
                n_simple = (i_d > i_c) ? i_d - i_c : 8'd0;
            end
            bmpm_pkg::MODE_DIFF: begin
                n_simple = (i_c > i_d) ? i_c - i_d : i_d - i_c;
            end
            bmpm_pkg::MODE_REV_SUB: begin
                n_simple = (i_c > i_d) ? i_c - i_d : 8'd0;
            end
            bmpm_pkg::MODE_INV_SUB: begin
                n_simple = (i_c > w_inv_d) ? i_c - w_inv_d : 8'd0;
            end
            default: begin
                n_simple = i_c;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_prod   <= w_opc * w_opd;
            r_simple <= n_simple;
            r_mode   <= i_mode;
            r_inv    <= w_inv;
            r_d1     <= i_d;
        end
    end

    assign w_q  = bmpm_pkg::div255(r_prod);
    // The quotient stays below 128 in overlay, so doubling fits in a byte.
    assign w_q2 = {w_q[6:0], 1'b0};

    always_comb begin
        case (r_mode)
            bmpm_pkg::MODE_OVERLAY: begin
                n_b = r_inv ? bmpm_pkg::CHAN_MAX - w_q2 : w_q2;
            end
            bmpm_pkg::MODE_MULTIPLY: begin
                n_b = w_q;
            end
            bmpm_pkg::MODE_SCREEN: begin
                n_b = bmpm_pkg::CHAN_MAX - w_q;
            end
            default: begin
                n_b = r_simple;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_b2 <= n_b;
            r_d2 <= r_d1;
        end
    end

    assign o_b = r_b2;
    assign o_d = r_d2;

endmodule

`default_nettype wire

FILE: rtl/bmpm_mix_chan.sv
// One channel of the final alpha mix: (d*(256-a) + b*(a+1)) >> 8, registered.
// Depends on bmpm_pkg for the alpha constant.
`default_nettype none

module bmpm_mix_chan (
    input  wire logic       i_clk,
    input  wire logic       i_en,
    input  wire logic [7:0] i_d,
    input  wire logic [7:0] i_b,
    input  wire logic [7:0] i_a,
    output logic      [7:0] o_m
);

    logic [8:0]  w_ia;
    logic [8:0]  w_ap;
    logic [16:0] w_mix;
    logic [7:0]  r_m;

    assign w_ia  = bmpm_pkg::ALPHA_ONE - {1'b0, i_a};
    assign w_ap  = {1'b0, i_a} + 9'd1;
    // The weights sum to 257, so the total never exceeds 16 bits.
    assign w_mix = ({9'd0, i_d} * {8'd0, w_ia}) + ({9'd0, i_b} * {8'd0, w_ap});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m <= w_mix[15:8];
        end
    end

    assign o_m = r_m;

endmodule

`default_nettype wire
